[sv/skf_pkg.sv]
`timescale 1ns / 1ps

package skf_pkg;

   // Field width of measurement, estimate and noise registers
   localparam int DATA_W = 32;

   // Configuration port geometry: two 32-bit registers at byte offsets 0 and 4
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register select codes (byte address bit 2)
   localparam logic REG_PROCESS_NOISE = 1'b0;
   localparam logic REG_MEASURE_NOISE = 1'b1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRIOR,
      ST_DENOM,
      ST_DIVIDE,
      ST_MUL_EST,
      ST_MUL_COV,
      ST_COMMIT
   } skf_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;       // latch the accepted measurement
      logic prior;      // form saturated prior and innovation
      logic denom;      // form denominator, seed the divider
      logic div_step;   // one quotient bit of the gain
      logic div_first;  // first quotient bit: compare without shift
      logic mul_est;    // multiply innovation by gain
      logic mul_cov;    // multiply prior by one minus gain, round estimate
      logic commit;     // update state and present the result
   } skf_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic out_busy;   // result register still holds an untaken result
   } skf_status_type;

endpackage

[sv/skf_if.sv]
`timescale 1ns / 1ps

// Measurement channel
interface skf_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [skf_pkg::DATA_W-1:0]   measurement;

   modport source (output valid, output measurement, input ready);
   modport sink (input valid, input measurement, output ready);
endinterface

// Estimate channel
interface skf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [skf_pkg::DATA_W-1:0]   estimate;

   modport source (output valid, output estimate, input ready);
   modport sink (input valid, input estimate, output ready);
endinterface

[sv/skf_csr.sv]
`timescale 1ns / 1ps

module skf_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [skf_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [skf_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [skf_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output logic [skf_pkg::DATA_W-1:0]      process_noise,
   output logic [skf_pkg::DATA_W-1:0]      measure_noise
);
   import skf_pkg::*;

   localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = DATA_W'(1180);
   localparam logic [DATA_W-1:0] MEASURE_NOISE_RST = DATA_W'(35520);

   logic [DATA_W-1:0] process_noise_ff, process_noise_in;
   logic [DATA_W-1:0] measure_noise_ff, measure_noise_in;
   logic              wr_en;

   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;

   // Decode register writes on the word select bit
   always_comb begin
      process_noise_in = process_noise_ff;
      measure_noise_in = measure_noise_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_PROCESS_NOISE: process_noise_in = pwdata;
            REG_MEASURE_NOISE: measure_noise_in = pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         process_noise_ff <= PROCESS_NOISE_RST;
         measure_noise_ff <= MEASURE_NOISE_RST;
      end else begin
         process_noise_ff <= process_noise_in;
         measure_noise_ff <= measure_noise_in;
      end
   end

   // Read back
   always_comb begin
      case (paddr[2])
         REG_PROCESS_NOISE: prdata = process_noise_ff;
         REG_MEASURE_NOISE: prdata = measure_noise_ff;
         default:           prdata = '0;
      endcase
   end

   assign process_noise = process_noise_ff;
   assign measure_noise = measure_noise_ff;

endmodule

[sv/skf_ctrl.sv]
`timescale 1ns / 1ps

module skf_ctrl #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  skf_pkg::skf_status_type status,
   output skf_pkg::skf_cmd_type    cmd
);
   import skf_pkg::*;

   // Divider produces FRAC_BITS+1 quotient bits, counted down to zero
   localparam int CNT_W = $clog2(FRAC_BITS + 1);
   localparam logic [CNT_W-1:0] CNT_START = CNT_W'(FRAC_BITS);

   skf_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Next state and quotient bit counter
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PRIOR;
         end
         ST_PRIOR: begin
            state_in = ST_DENOM;
         end
         ST_DENOM: begin
            state_in = ST_DIVIDE;
            cnt_in   = CNT_START;
         end
         ST_DIVIDE: begin
            if (cnt_ff == '0) begin
               state_in = ST_MUL_EST;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_MUL_EST: begin
            state_in = ST_MUL_COV;
         end
         ST_MUL_COV: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // hold until the result register is free
            if (!status.out_busy) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Datapath commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_PRIOR:   cmd.prior = 1'b1;
         ST_DENOM:   cmd.denom = 1'b1;
         ST_DIVIDE: begin
            cmd.div_step  = 1'b1;
            cmd.div_first = (cnt_ff == CNT_START);
         end
         ST_MUL_EST: cmd.mul_est = 1'b1;
         ST_MUL_COV: cmd.mul_cov = 1'b1;
         ST_COMMIT:  cmd.commit  = !status.out_busy;
         default: ;
      endcase
   end

endmodule

[sv/skf_datapath.sv]
`timescale 1ns / 1ps

module skf_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  skf_pkg::skf_cmd_type               cmd,
   output skf_pkg::skf_status_type            status,
   input  logic signed [skf_pkg::DATA_W-1:0]  measurement,
   input  logic [skf_pkg::DATA_W-1:0]         process_noise,
   input  logic [skf_pkg::DATA_W-1:0]         measure_noise,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [skf_pkg::DATA_W-1:0]  estimate
);
   import skf_pkg::*;

   localparam int GAIN_W = FRAC_BITS + 1;             // gain 0 .. 1.0 inclusive
   localparam int MB_W   = GAIN_W + 1;                // signed multiplier operand b
   localparam int MA_W   = DATA_W + 1;                // signed multiplier operand a
   localparam int PROD_W = MA_W + MB_W;
   localparam int CORR_W = PROD_W - FRAC_BITS;
   localparam int DEN_W  = DATA_W + 1;
   localparam int REM_W  = DATA_W + 2;
   localparam logic [GAIN_W-1:0] GAIN_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic [DATA_W-1:0] EST_MAX    = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] EST_MIN    = {1'b1, {(DATA_W-1){1'b0}}};

   logic signed [DATA_W-1:0] meas_ff, meas_in;
   logic signed [DATA_W-1:0] est_ff, est_in;
   logic [DATA_W-1:0]        cov_ff, cov_in;
   logic [DATA_W-1:0]        prior_ff, prior_in;
   logic signed [MA_W-1:0]   diff_ff, diff_in;
   logic [DEN_W-1:0]         denom_ff, denom_in;
   logic                     dzero_ff, dzero_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [GAIN_W-1:0]        gain_ff, gain_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [DATA_W-1:0] next_est_ff, next_est_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic [DATA_W:0]          prior_sum;
   logic [REM_W-1:0]         trial;
   logic                     trial_ge;
   logic signed [MA_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] rounded;
   logic signed [CORR_W-1:0] corr;
   logic signed [CORR_W-1:0] est_sum;
   logic [GAIN_W-1:0]        one_minus_gain;

   // Prior: covariance plus process noise, clamped to full scale
   assign prior_sum = {1'b0, cov_ff} + {1'b0, process_noise};

   // Restoring divider: first bit compares unshifted, later bits shift in a zero
   assign trial    = cmd.div_first ? rem_ff : {rem_ff[REM_W-2:0], 1'b0};
   assign trial_ge = (trial >= {1'b0, denom_ff});

   // Shared multiplier operands
   assign one_minus_gain = GAIN_ONE - gain_ff;
   always_comb begin
      if (cmd.mul_cov) begin
         mul_a = {1'b0, prior_ff};
         mul_b = {1'b0, one_minus_gain};
      end else begin
         mul_a = diff_ff;
         mul_b = {1'b0, gain_ff};
      end
   end

   // Round correction to nearest, ties up, then add and saturate
   assign rounded = prod_ff + ROUND_HALF;
   assign corr    = rounded[PROD_W-1:FRAC_BITS];
   assign est_sum = {{(CORR_W-DATA_W){est_ff[DATA_W-1]}}, est_ff} + corr;

   always_comb begin
      meas_in      = meas_ff;
      est_in       = est_ff;
      cov_in       = cov_ff;
      prior_in     = prior_ff;
      diff_in      = diff_ff;
      denom_in     = denom_ff;
      dzero_in     = dzero_ff;
      rem_in       = rem_ff;
      gain_in      = gain_ff;
      prod_in      = prod_ff;
      next_est_in  = next_est_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      if (cmd.load) meas_in = measurement;

      if (cmd.prior) begin
         prior_in = prior_sum[DATA_W] ? '1 : prior_sum[DATA_W-1:0];
         diff_in  = {meas_ff[DATA_W-1], meas_ff} - {est_ff[DATA_W-1], est_ff};
      end

      if (cmd.denom) begin
         denom_in = {1'b0, prior_ff} + {1'b0, measure_noise};
         dzero_in = (prior_ff == '0) && (measure_noise == '0);
         rem_in   = {2'b00, prior_ff};
         gain_in  = '0;
      end

      // zero denominator forces a zero gain
      if (cmd.div_step) begin
         rem_in  = trial_ge ? (trial - {1'b0, denom_ff}) : trial;
         gain_in = {gain_ff[GAIN_W-2:0], trial_ge & ~dzero_ff};
      end

      if (cmd.mul_est || cmd.mul_cov) prod_in = mul_a * mul_b;

      if (cmd.mul_cov) begin
         if (est_sum[CORR_W-1:DATA_W-1] == {(CORR_W-DATA_W+1){est_sum[CORR_W-1]}}) begin
            next_est_in = est_sum[DATA_W-1:0];
         end else begin
            next_est_in = est_sum[CORR_W-1] ? EST_MIN : EST_MAX;
         end
      end

      // Commit state and present the new estimate
      if (cmd.commit) begin
         cov_in       = prod_ff[FRAC_BITS+DATA_W-1:FRAC_BITS];
         est_in       = next_est_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff       <= '0;
         cov_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         est_ff       <= est_in;
         cov_ff       <= cov_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      meas_ff     <= meas_in;
      prior_ff    <= prior_in;
      diff_ff     <= diff_in;
      denom_ff    <= denom_in;
      dzero_ff    <= dzero_in;
      rem_ff      <= rem_in;
      gain_ff     <= gain_in;
      prod_ff     <= prod_in;
      next_est_ff <= next_est_in;
   end

   // est_ff only changes at commit, which waits for the result register to drain
   assign status.out_busy = rsp_valid_ff & ~rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign estimate        = est_ff;

endmodule

[sv/scalar_kalman_filter.sv]
// One-dimensional Kalman filter on signed Q16.16 samples (FRAC_BITS fraction bits).
// Each measurement transfer yields exactly one estimate transfer. Items are
// processed one at a time: an accepted measurement keeps the block busy through
// the prior, denominator, divide, multiply and commit states. The busy time
// is set by the restoring divider for the gain, which retires one quotient bit
// per cycle, FRAC_BITS + 1 bits in all, plus one shared multiplier used twice.
// The estimate sits in an output register, so a new measurement is taken while
// the previous result waits; the next result is held back only until that one
// is taken. Registers: process_noise at byte 0x0, measure_noise at 0x4, written
// with APB-style setup and access cycles; the user must write them only while
// the block is idle, and the block does not enforce this; pready is tied high.
`timescale 1ns / 1ps

module scalar_kalman_filter #(
   parameter int FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   skf_req_if.sink                         req_ch,
   skf_rsp_if.source                       rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [skf_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [skf_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [skf_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import skf_pkg::*;

   skf_cmd_type       cmd;
   skf_status_type    status;
   logic [DATA_W-1:0] process_noise;
   logic [DATA_W-1:0] measure_noise;

   skf_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .process_noise (process_noise),
      .measure_noise (measure_noise)
   );

   skf_ctrl #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   skf_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .measurement   (req_ch.measurement),
      .process_noise (process_noise),
      .measure_noise (measure_noise),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .estimate      (rsp_ch.estimate)
   );

endmodule

[sv/skf_checker.sv]
`timescale 1ns / 1ps

module skf_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic signed [skf_pkg::DATA_W-1:0]  rsp_estimate
);

   // One item in flight: no second transfer right after an accepted one
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("skf: input ready right after a measurement transfer");

   // A result needs the whole step: none appears the cycle after acceptance
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("skf: estimate valid too early after a measurement transfer");

   // A stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("skf: estimate dropped while stalled");

   // A stalled result holds its value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_estimate))
      else $error("skf: estimate changed while stalled");

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_estimate (rsp_ch.estimate)
);
